@@ rtl/core/marf_pkg.sv @@
// Package for the multichannel AR residual filter.
// Sizes, field widths, result codes and the control structs shared by the core modules.
// No dependencies.
package marf_pkg;

    localparam int MAX_CHANNELS        = 8;
    localparam int MAX_LAGS            = 16;
    localparam int COEFF_FRACTION_BITS = 14;

    localparam int CH_W     = $clog2(MAX_CHANNELS);
    localparam int LAG_W    = $clog2(MAX_LAGS);
    localparam int CHC_W    = $clog2(MAX_CHANNELS + 1);
    localparam int LAGC_W   = $clog2(MAX_LAGS + 1);
    localparam int HIST_AW  = LAG_W + CH_W;
    localparam int COEF_AW  = 2 * CH_W + LAG_W;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int RES_W    = 20;
    localparam int SQ_W     = 2 * RES_W;
    localparam int ACC_W    = 40;
    localparam int SUM_W    = 60;
    localparam int CNT_W    = 20;
    localparam int DIV_W    = CNT_W + 1;
    localparam int ROOT_W   = RES_W - 1;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [1:0] KIND_RES  = 2'd0;
    localparam logic [1:0] KIND_WARM = 2'd1;
    localparam logic [1:0] KIND_RMS  = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    localparam logic CFG_CHANNELS = 1'b0;
    localparam logic CFG_LAGS     = 1'b1;

    typedef struct packed {
        logic start;
        logic term_valid;
    } t_mac_ctl;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   sum;
        logic [DIV_W-1:0]   div;
    } t_rms_req;

    typedef struct packed {
        logic               done;
        logic [ROOT_W-1:0]  root;
    } t_rms_rsp;

endpackage

@@ rtl/core/marf_mac.sv @@
// Multiply-accumulate unit of the AR residual filter: one coefficient term a cycle,
// registered product, then rounding and saturation of the residual.
// Depends on marf_pkg.
module marf_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  marf_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [marf_pkg::SAMPLE_W-1:0]  i_value,
    input  logic signed [marf_pkg::SAMPLE_W-1:0]  i_coef,
    input  logic signed [marf_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                  o_busy,
    output logic signed [marf_pkg::RES_W-1:0]     o_res
);
    import marf_pkg::*;

    localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'((1 <<< (RES_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] RES_MIN = -ACC_W'(1 <<< (RES_W - 1));
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1 <<< (COEFF_FRACTION_BITS - 1));

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rounded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_ctl.start) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.term_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.term_valid) begin
            r_prod <= i_coef * i_sample;
        end
        if (i_ctl.start) begin
            r_acc <= ACC_W'(i_value) <<< COEFF_FRACTION_BITS;
        end else if (r_v2) begin
            r_acc <= r_acc - ACC_W'(r_prod);
        end
    end

    assign rounded = (r_acc + HALF) >>> COEFF_FRACTION_BITS;
    assign o_busy  = r_v2;

    always_comb begin
        if (rounded > RES_MAX) begin
            o_res = RES_MAX[RES_W-1:0];
        end else if (rounded < RES_MIN) begin
            o_res = RES_MIN[RES_W-1:0];
        end else begin
            o_res = rounded[RES_W-1:0];
        end
    end

endmodule

@@ rtl/core/marf_rms.sv @@
// RMS unit of the AR residual filter: restoring divide of the squared sum by the
// residual count, one bit a cycle, then a bitwise integer square root, clamped.
// Depends on marf_pkg.
module marf_rms (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  marf_pkg::t_rms_req i_req,
    output marf_pkg::t_rms_rsp o_rsp
);
    import marf_pkg::*;

    localparam int ITER_W = $clog2(SUM_W);
    localparam logic [SUM_W-1:0] ROOT_MAX = SUM_W'((1 << ROOT_W) - 1);

    typedef enum logic [2:0] {
        RS_IDLE = 3'b001,
        RS_DIV  = 3'b010,
        RS_SQRT = 3'b100
    } t_rstate;

    t_rstate            r_state;
    logic [ITER_W-1:0]  r_iter;
    logic [SUM_W-1:0]   r_num;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [SUM_W-1:0]   r_x;
    logic [SUM_W-1:0]   r_root;
    logic [SUM_W-1:0]   r_bit;
    logic               r_done;
    logic [ROOT_W-1:0]  r_out;

    logic [DIV_W:0]     rem2;
    logic               ge;
    logic [SUM_W-1:0]   quot;
    logic [SUM_W-1:0]   trial;
    logic               fit;
    logic [SUM_W-1:0]   n_root;

    assign rem2   = {r_rem, r_num[SUM_W-1]};
    assign ge     = rem2 >= {1'b0, r_div};
    assign quot   = {r_num[SUM_W-2:0], ge};
    assign trial  = r_root + r_bit;
    assign fit    = r_x >= trial;
    assign n_root = fit ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                RS_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.div == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= RS_DIV;
                        end
                    end
                end
                RS_DIV: begin
                    if (r_iter == '0) begin
                        r_state <= RS_SQRT;
                    end
                end
                RS_SQRT: begin
                    if (r_iter == '0) begin
                        r_state <= RS_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= RS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            RS_IDLE: begin
                r_num  <= i_req.sum;
                r_div  <= i_req.div;
                r_rem  <= '0;
                r_iter <= ITER_W'(SUM_W - 1);
                r_out  <= '0;
            end
            RS_DIV: begin
                r_rem <= ge ? DIV_W'(rem2 - {1'b0, r_div}) : rem2[DIV_W-1:0];
                r_num <= quot;
                if (r_iter == '0) begin
                    r_x    <= quot;
                    r_root <= '0;
                    r_bit  <= SUM_W'(1) << (SUM_W - 2);
                    r_iter <= ITER_W'(SUM_W / 2 - 1);
                end else begin
                    r_iter <= r_iter - ITER_W'(1);
                end
            end
            RS_SQRT: begin
                if (fit) begin
                    r_x <= r_x - trial;
                end
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                r_iter <= r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    r_out <= (n_root > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : n_root[ROOT_W-1:0];
                end
            end
            default: r_iter <= '0;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_out;

endmodule

@@ rtl/core/multichannel_ar_residual_filter.sv @@
// Top level of the multichannel AR residual filter: control sequencer, coefficient
// and sample-history memories, per-channel squared sums and the output register.
// Depends on marf_pkg, marf_mac and marf_rms.
//
// A coefficient item is written to the coefficient memory as it is accepted. A sample
// item during warm-up goes from idle straight to the emit state; otherwise its residual
// runs the single multiply-accumulate loop over every channel and lag in use, reading
// one coefficient and one past sample a cycle from the two memories, then passes the
// drain, round, square and sum states. The sample that closes a time step then copies
// every channel slot of the step into the history memory. The last sample of a series
// runs the bit-serial divide and square root once per channel in use. The result register
// lets the next item in while a result waits. History starts at zero after reset and after
// each series through row valid bits; coefficients must be written before use.
module multichannel_ar_residual_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // target_channel[2:0], source_channel[5:3],
                                     // lag_index[9:6], value[25:10], zero[31:26]
    input  logic        i_s_tuser,   // mode[0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // channel[2:0], result_value[22:3], zero[23]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    import marf_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MAC   = 10'b0000000010,
        ST_DRAIN = 10'b0000000100,
        ST_ROUND = 10'b0000001000,
        ST_SQ    = 10'b0000010000,
        ST_SUM   = 10'b0000100000,
        ST_EMIT  = 10'b0001000000,
        ST_COPY  = 10'b0010000000,
        ST_RMS   = 10'b0100000000,
        ST_EMITR = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [CHC_W-1:0]  r_chans_cfg;
    logic [LAGC_W-1:0] r_lags_cfg;
    logic [CHC_W-1:0]  eff_ch;
    logic [LAGC_W-1:0] eff_lg;

    logic signed [SAMPLE_W-1:0] coef_mem [2**COEF_AW];
    logic signed [SAMPLE_W-1:0] hist_mem [2**HIST_AW];
    logic signed [SAMPLE_W-1:0] r_coef_q;
    logic signed [SAMPLE_W-1:0] r_hist_q;

    logic signed [SAMPLE_W-1:0] r_cur [MAX_CHANNELS];
    logic [SUM_W-1:0]           r_sum [MAX_CHANNELS];
    logic [MAX_LAGS-1:0]        r_rowv;

    logic [CH_W-1:0]   r_pos, r_d, r_i, r_k, r_rms_ch;
    logic [LAG_W-1:0]  r_j, r_head;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_div;
    logic              r_last, r_warm, r_v1, r_rowv1, r_rms_start;
    logic signed [RES_W-1:0] r_res;
    logic signed [SQ_W-1:0]  r_sq;
    logic [ROOT_W-1:0] r_root;

    logic              r_out_valid, r_out_last;
    logic [1:0]        r_out_kind;
    logic [CH_W-1:0]   r_out_ch;
    logic [RES_W-1:0]  r_out_val;

    logic              s_acc, slot_free, mac_last, step_end, rms_last, out_load, rms_go;
    logic [CH_W-1:0]   in_tgt, in_src, d_sel;
    logic [LAG_W-1:0]  in_lag, slot;
    logic signed [SAMPLE_W-1:0] in_val;
    logic [DIV_W-1:0]  steps;
    logic [SUM_W:0]    sum_add;

    t_mac_ctl          mac_ctl;
    logic              mac_busy;
    logic signed [RES_W-1:0] mac_res;
    t_rms_req          rms_req;
    t_rms_rsp          rms_rsp;

    assign in_tgt = i_s_tdata[2:0];
    assign in_src = i_s_tdata[5:3];
    assign in_lag = i_s_tdata[9:6];
    assign in_val = i_s_tdata[25:10];

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign slot_free   = !r_out_valid || i_m_tready;
    assign out_load    = slot_free && ((r_state == ST_EMIT) || (r_state == ST_EMITR));
    assign rms_go      = slot_free && (((r_state == ST_EMIT) && r_last) ||
                                       ((r_state == ST_EMITR) && !rms_last));

    always_comb begin
        if (r_chans_cfg == '0) begin
            eff_ch = CHC_W'(1);
        end else if (r_chans_cfg > CHC_W'(MAX_CHANNELS)) begin
            eff_ch = CHC_W'(MAX_CHANNELS);
        end else begin
            eff_ch = r_chans_cfg;
        end
        if (r_lags_cfg == '0) begin
            eff_lg = LAGC_W'(1);
        end else if (r_lags_cfg > LAGC_W'(MAX_LAGS)) begin
            eff_lg = LAGC_W'(MAX_LAGS);
        end else begin
            eff_lg = r_lags_cfg;
        end
    end

    assign d_sel    = (CHC_W'(r_pos) >= eff_ch) ? '0 : r_pos;
    assign slot     = r_head - r_j;
    assign mac_last = (CHC_W'(r_i) == eff_ch - CHC_W'(1)) &&
                      (LAGC_W'(r_j) == eff_lg - LAGC_W'(1));
    assign step_end = (CHC_W'(r_d) + CHC_W'(1)) >= eff_ch;
    assign rms_last = (CHC_W'(r_rms_ch) + CHC_W'(1)) == eff_ch;
    assign steps    = DIV_W'(r_cnt) + DIV_W'(1);
    assign sum_add  = {1'b0, r_sum[r_d]} + (SUM_W + 1)'($unsigned(r_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans_cfg <= CHC_W'(1);
            r_lags_cfg  <= LAGC_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNELS: r_chans_cfg <= i_cfg_data[CHC_W-1:0];
                CFG_LAGS:     r_lags_cfg  <= i_cfg_data[LAGC_W-1:0];
                default:      r_lags_cfg  <= r_lags_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tuser == MODE_COEF) begin
            coef_mem[{in_tgt, in_src, in_lag}] <= in_val;
        end
        r_coef_q <= coef_mem[{r_d, r_i, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_COPY) begin
            hist_mem[{r_head, r_k}] <= r_cur[r_k];
        end
        r_hist_q <= hist_mem[{slot, r_i}];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && i_s_tuser == MODE_SAMPLE) begin
                    n_state = (r_cnt < CNT_W'(eff_lg)) ? ST_EMIT : ST_MAC;
                end
            end
            ST_MAC:   if (mac_last) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_v1 && !mac_busy) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SQ;
            ST_SQ:    n_state = ST_SUM;
            ST_SUM:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    priority if (r_last)   n_state = ST_RMS;
                    else if (step_end)     n_state = ST_COPY;
                    else                   n_state = ST_IDLE;
                end
            end
            ST_COPY:  if (r_k == CH_W'(MAX_CHANNELS - 1)) n_state = ST_IDLE;
            ST_RMS:   if (rms_rsp.done) n_state = ST_EMITR;
            ST_EMITR: begin
                if (slot_free) n_state = rms_last ? ST_IDLE : ST_RMS;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_head      <= '0;
            r_rowv      <= '0;
            r_v1        <= 1'b0;
            r_rms_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_cur[c] <= '0;
                r_sum[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_v1        <= (r_state == ST_MAC);
            r_rms_start <= rms_go;
            r_out_valid <= out_load || (r_out_valid && !i_m_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc && i_s_tuser == MODE_SAMPLE) begin
                        r_cur[d_sel] <= in_val;
                    end
                end
                ST_SUM: begin
                    r_sum[r_d] <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                end
                ST_EMIT: begin
                    if (slot_free && !r_last) begin
                        if (step_end) begin
                            r_pos  <= '0;
                            r_head <= r_head + LAG_W'(1);
                            if (r_cnt != {CNT_W{1'b1}}) begin
                                r_cnt <= r_cnt + CNT_W'(1);
                            end
                        end else begin
                            r_pos <= r_d + CH_W'(1);
                        end
                    end
                end
                ST_COPY: begin
                    r_rowv[r_head] <= 1'b1;
                end
                ST_EMITR: begin
                    if (slot_free && rms_last) begin
                        r_pos  <= '0;
                        r_cnt  <= '0;
                        r_rowv <= '0;
                        for (int c = 0; c < MAX_CHANNELS; c++) begin
                            r_cur[c] <= '0;
                            r_sum[c] <= '0;
                        end
                    end
                end
                default: r_pos <= r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rowv1 <= r_rowv[slot];
        unique case (r_state)
            ST_IDLE: begin
                r_d    <= d_sel;
                r_last <= i_s_tlast;
                r_warm <= (r_cnt < CNT_W'(eff_lg));
                r_res  <= '0;
                r_i    <= '0;
                r_j    <= '0;
            end
            ST_MAC: begin
                if (LAGC_W'(r_j) == eff_lg - LAGC_W'(1)) begin
                    r_j <= '0;
                    r_i <= r_i + CH_W'(1);
                end else begin
                    r_j <= r_j + LAG_W'(1);
                end
            end
            ST_ROUND: r_res <= mac_res;
            ST_SQ:    r_sq  <= r_res * r_res;
            ST_EMIT: begin
                r_k      <= '0;
                r_rms_ch <= '0;
                r_div    <= (steps > DIV_W'(eff_lg)) ? steps - DIV_W'(eff_lg) : '0;
                if (slot_free) begin
                    r_out_kind <= r_warm ? KIND_WARM : KIND_RES;
                    r_out_ch   <= r_d;
                    r_out_val  <= r_res;
                    r_out_last <= !r_last;
                end
            end
            ST_COPY: r_k <= r_k + CH_W'(1);
            ST_RMS:  if (rms_rsp.done) r_root <= rms_rsp.root;
            ST_EMITR: begin
                if (slot_free) begin
                    r_out_kind <= KIND_RMS;
                    r_out_ch   <= r_rms_ch;
                    r_out_val  <= RES_W'(r_root);
                    r_out_last <= rms_last;
                    r_rms_ch   <= r_rms_ch + CH_W'(1);
                end
            end
            default: r_k <= r_k;
        endcase
    end

    assign mac_ctl.start      = s_acc && (i_s_tuser == MODE_SAMPLE);
    assign mac_ctl.term_valid = r_v1;

    marf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_value  (in_val),
        .i_coef   (r_coef_q),
        .i_sample (r_rowv1 ? r_hist_q : '0),
        .o_busy   (mac_busy),
        .o_res    (mac_res)
    );

    assign rms_req.start = r_rms_start;
    assign rms_req.sum   = r_sum[r_rms_ch];
    assign rms_req.div   = r_div;

    marf_rms u_rms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rms_req),
        .o_rsp   (rms_rsp)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_val, r_out_ch};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

@@ rtl/core/marf_checker.sv @@
// Port-level checker for the multichannel AR residual filter, bound to the top level.
// Depends on marf_pkg and multichannel_ar_residual_filter.
module marf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import marf_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_RES) || (o_m_tuser == KIND_WARM) ||
        (o_m_tuser == KIND_RMS))
        else $error("unknown result kind");

    a_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_WARM) |-> (o_m_tdata[22:3] == '0))
        else $error("warm-up residual not zero");

    a_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_RMS) |-> !o_m_tdata[22])
        else $error("rms result negative");

endmodule

bind multichannel_ar_residual_filter marf_checker u_marf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
